[rtl/ebps_pkg.sv]
package ebps_pkg;

  // Fixed layout of the pattern registers
  localparam int PATTERN_WORDS = 6;
  localparam int PATTERN_BYTES = 8 * PATTERN_WORDS;
  localparam int RVA_W         = 32;
  localparam int INDEX_W       = 6;
  localparam int PLEN_W        = 6;
  localparam int REG_INDEX_W   = 3;

  // Register indexes
  localparam logic [REG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PATTERN_WORD_5 = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd6;

  localparam logic [PLEN_W-1:0] PATTERN_LENGTH_RESET = 6'd48;

  typedef logic [63:0] pattern_word_t;
  typedef logic [7:0]  byte_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             scan_start;
    logic             section_first;
    logic             section_executable;
    logic [RVA_W-1:0] section_rva;
  } byte_item_t;

  typedef struct packed {
    logic [RVA_W-1:0]   match_rva;
    logic [INDEX_W-1:0] match_index;
    logic               limit_reached;
  } match_item_t;

  typedef struct packed {
    logic [REG_INDEX_W-1:0] reg_index;
    logic [63:0]            reg_value;
  } cfg_write_t;

endpackage

[rtl/ebps_chan_if.sv]
interface ebps_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/ebps_cell.sv]
module ebps_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  ebps_pkg::byte_t byte_in,
  input  ebps_pkg::byte_t pattern_byte,
  input  logic           in_use,
  output ebps_pkg::byte_t byte_out,
  output logic           ok
);
  import ebps_pkg::*;

  byte_t window_byte;

  // Take the neighbour's byte on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      window_byte <= byte_in;
    end
  end

  assign byte_out = window_byte;

  // A cell beyond the pattern length never blocks a match
  assign ok = !in_use || (window_byte == pattern_byte);

endmodule

[rtl/ebps_align.sv]
module ebps_align #(
  parameter int MAX_PATTERN_BYTES = 48,
  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  ebps_pkg::pattern_word_t pattern_word [ebps_pkg::PATTERN_WORDS],
  input  logic [LEN_W-1:0]        len,
  output ebps_pkg::byte_t         aligned [MAX_PATTERN_BYTES]
);
  import ebps_pkg::*;

  localparam int VEC_W = 8 * MAX_PATTERN_BYTES;

  logic [VEC_W-1:0] rev_vec;
  logic [VEC_W-1:0] shifted;
  logic [LEN_W-1:0] shift_amt;

  // Lay the pattern out last byte first; bytes past the registers read as zero
  for (genvar m = 0; m < MAX_PATTERN_BYTES; m++) begin : g_rev
    localparam int SRC = MAX_PATTERN_BYTES - 1 - m;
    if (SRC < PATTERN_BYTES) begin : g_reg
      assign rev_vec[m*8 +: 8] = pattern_word[SRC / 8][(SRC % 8) * 8 +: 8];
    end else begin : g_zero
      assign rev_vec[m*8 +: 8] = 8'h00;
    end
  end

  // Drop the unused tail so the last pattern byte lines up with the newest byte
  assign shift_amt = LEN_W'(MAX_PATTERN_BYTES) - len;
  assign shifted   = rev_vec >> {shift_amt, 3'b000};

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_out
    assign aligned[k] = shifted[k*8 +: 8];
  end

endmodule

[rtl/exact_byte_pattern_search.sv]
// Exact byte pattern search over a stream of section bytes.
// bytes: one word per data byte with scan_start, section_first, the section's
//   executable flag and virtual address (the last two taken on section_first).
// hits: one word per match with the address of its first byte, its ordinal
//   in the search and a flag on the last allowed match.
// cfg: register writes (pattern words 0 to 5, then pattern length); always
//   ready, write only while no byte is in flight.
// A byte is taken every cycle while the output can move. A byte's match word
// is loaded into the output register from the compare stage: the byte shifts
// into the row of window cells and the compare stage when it is taken, and
// the cell compares load the result register when the compare stage moves.
// Throughput is one byte per cycle while the output can move, set by the
// single shift of the cell row. When hits stalls, a full compare stage and
// the window hold and bytes.ready falls until the output register is taken.
// Reset clears the pattern registers, sets the length to 48, leaves the
// section inactive and the match count at zero; the window needs no clearing
// since its fill count starts at zero.
module exact_byte_pattern_search #(
  parameter int MAX_PATTERN_BYTES = 48,
  parameter int MAX_MATCHES       = 64
) (
  input logic clk,
  input logic rst,
  ebps_chan_if.sink   bytes,
  ebps_chan_if.source hits,
  ebps_chan_if.sink   cfg
);
  import ebps_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int CNT_W = $clog2(MAX_MATCHES + 1);

  // Configuration registers
  pattern_word_t     pattern_word [PATTERN_WORDS];
  logic [PLEN_W-1:0] pattern_length;

  // Section state
  logic [LEN_W-1:0]  window_fill;
  logic [RVA_W-1:0]  section_offset;
  logic [RVA_W-1:0]  section_base;
  logic              section_active;
  logic [CNT_W-1:0]  match_count;

  // Compare stage
  logic              b_valid;
  logic              b_active;
  logic              b_scan;
  logic [LEN_W-1:0]  b_fill;
  logic [RVA_W-1:0]  b_pos;
  logic [RVA_W-1:0]  b_base;

  // Output register
  logic              out_valid;
  match_item_t       out_item;

  byte_item_t        in_item;
  logic              in_accept;
  logic              out_free;
  logic              b_move;
  logic              shift_en;

  logic [LEN_W-1:0]  len;
  byte_t             aligned [MAX_PATTERN_BYTES];
  byte_t             window  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_ok;

  logic              fill_clr;
  logic              active_a;
  logic [RVA_W-1:0]  base_a;
  logic [RVA_W-1:0]  offset_a;
  logic [LEN_W-1:0]  fill_a;
  logic [LEN_W-1:0]  fill_next;

  logic [CNT_W-1:0]  count_eff;
  logic              hit;

  assign in_item   = bytes.data;
  assign out_free  = !out_valid || hits.ready;
  assign bytes.ready = !b_valid || out_free;
  assign in_accept = bytes.valid && bytes.ready;
  assign b_move    = b_valid && out_free;
  assign cfg.ready = 1'b1;

  assign hits.valid = out_valid;
  assign hits.data  = out_item;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
      pattern_length <= PATTERN_LENGTH_RESET;
    end else if (cfg.valid) begin
      if (cfg.data.reg_index <= REG_PATTERN_WORD_5) begin
        pattern_word[cfg.data.reg_index] <= cfg.data.reg_value;
      end else if (cfg.data.reg_index == REG_PATTERN_LENGTH) begin
        pattern_length <= cfg.data.reg_value[PLEN_W-1:0];
      end
    end
  end

  // Clamp the pattern length to one .. MAX_PATTERN_BYTES
  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if ({1'b0, pattern_length} > 7'(MAX_PATTERN_BYTES)) begin
      len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len = LEN_W'(pattern_length);
    end
  end

  ebps_align #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_align (
    .pattern_word (pattern_word),
    .len          (len),
    .aligned      (aligned)
  );

  // Apply scan start, then section start, to the section state
  always_comb begin
    fill_clr = in_item.scan_start || in_item.section_first;
    active_a = in_item.section_first ? in_item.section_executable : section_active;
    base_a   = in_item.section_first ? in_item.section_rva : section_base;
    offset_a = in_item.section_first ? '0 : section_offset;
    fill_a   = fill_clr ? '0 : window_fill;
    if (fill_a == LEN_W'(MAX_PATTERN_BYTES)) begin
      fill_next = fill_a;
    end else begin
      fill_next = fill_a + LEN_W'(1);
    end
  end

  assign shift_en = in_accept && active_a;

  // Row of window cells, newest byte in cell zero
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    byte_t nb_in;
    if (k == 0) begin : g_head
      assign nb_in = in_item.data_byte;
    end else begin : g_body
      assign nb_in = window[k-1];
    end
    ebps_cell u_cell (
      .clk          (clk),
      .shift_en     (shift_en),
      .byte_in      (nb_in),
      .pattern_byte (aligned[k]),
      .in_use       (LEN_W'(k) < len),
      .byte_out     (window[k]),
      .ok           (cell_ok[k])
    );
  end

  // Advance section state and load the compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill    <= '0;
      section_offset <= '0;
      section_base   <= '0;
      section_active <= 1'b0;
      b_valid        <= 1'b0;
    end else if (in_accept) begin
      section_active <= active_a;
      section_base   <= base_a;
      if (active_a) begin
        window_fill    <= fill_next;
        section_offset <= offset_a + RVA_W'(1);
      end else begin
        window_fill    <= fill_a;
        section_offset <= offset_a;
      end
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_active <= active_a;
      b_scan   <= in_item.scan_start;
      b_fill   <= fill_next;
      b_pos    <= offset_a;
      b_base   <= base_a;
    end
  end

  // Decide the match against the shifted window
  always_comb begin
    count_eff = b_scan ? '0 : match_count;
    hit = b_active && (b_fill >= len) && (count_eff < CNT_W'(MAX_MATCHES)) && (&cell_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (b_move) begin
        match_count <= count_eff + CNT_W'(hit);
      end
      if (b_move && hit) begin
        out_valid <= 1'b1;
      end else if (hits.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (b_move && hit) begin
      out_item.match_rva     <= b_base + b_pos - RVA_W'(len - LEN_W'(1));
      out_item.match_index   <= INDEX_W'(count_eff);
      out_item.limit_reached <= (count_eff + CNT_W'(1)) == CNT_W'(MAX_MATCHES);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    match_count <= CNT_W'(MAX_MATCHES))
    else $error("match count past limit");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill <= LEN_W'(MAX_PATTERN_BYTES))
    else $error("window fill past window size");

  a_limit_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.limit_reached |-> out_item.match_index == INDEX_W'(MAX_MATCHES - 1))
    else $error("limit flag on wrong match ordinal");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> b_valid)
    else $error("accepted byte lost before compare");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    b_valid && !out_free |=> b_valid && $stable(b_pos) && $stable(b_base))
    else $error("compare stage moved while output stalled");

endmodule
